### hw/rtl/sbcds_pkg.sv
// Shared constants and field types for the bit clock divider search block.
`timescale 1ns / 1ps
`default_nettype none

package sbcds_pkg;

   localparam int TARGET_W    = 32;
   localparam int REF_W       = 20;
   localparam int DIVIDE_W    = 8;
   localparam int RATE_FIELD_W = 8;
   localparam int ACHIEVED_W  = 20;

   localparam int HZ_PER_KHZ   = 1000;
   localparam int DIVIDE_FIRST = 2;
   localparam int DIVIDE_STEP  = 2;
   localparam int DIVIDE_LAST  = 254;
   localparam int RATE_MAX     = 256;
   localparam int REF_RESET    = 297731;

   // Register map (byte address is 4 times the index).
   localparam int CSR_ADDR_W           = 3;
   localparam int CSR_DATA_W           = 32;
   localparam logic CSR_IDX_REFERENCE  = 1'b0;

   typedef logic [TARGET_W-1:0]     target_hz_type;
   typedef logic [REF_W-1:0]        ref_khz_type;
   typedef logic [DIVIDE_W-1:0]     divide_type;
   typedef logic [RATE_FIELD_W-1:0] rate_field_type;
   typedef logic [ACHIEVED_W-1:0]   achieved_type;

endpackage

`default_nettype wire

### hw/rtl/sbcds_if.sv
// Valid/ready channel interfaces for the request and response transactions.
`timescale 1ns / 1ps
`default_nettype none

interface sbcds_req_if
   import sbcds_pkg::*;
   ();
   logic          valid;
   logic          ready;
   target_hz_type target_hz;

   modport source (output valid, output target_hz, input ready);
   modport sink   (input valid, input target_hz, output ready);
endinterface

interface sbcds_rsp_if
   import sbcds_pkg::*;
   ();
   logic           valid;
   logic           ready;
   divide_type     stage_divide;
   rate_field_type clock_rate_field;
   achieved_type   achieved_khz;
   logic           target_error;

   modport source (output valid, output stage_divide, output clock_rate_field,
                   output achieved_khz, output target_error, input ready);
   modport sink   (input valid, input stage_divide, input clock_rate_field,
                   input achieved_khz, input target_error, output ready);
endinterface

`default_nettype wire

### hw/rtl/ssp_bit_clock_divider_search.sv
// Top level of the two-stage serial bit clock divider search.
`timescale 1ns / 1ps
`default_nettype none

// Each request transaction carries a desired bit clock in Hz; the block answers
// with one response transaction holding the even first-stage divide (2..254),
// the second-stage rate minus one (saturated at 255) and the bit clock in kHz
// that the pair achieves, computed before the rate saturates. A target below
// 1 kHz raises target_error and returns divide 254, rate field 255 and 0 kHz.
// The source clock in kHz is a register at byte address 0 of the APB-style
// port (reset value 297731); write it only while no transaction is in flight.
// All arithmetic runs through one restoring divider that produces one quotient
// bit per cycle; a request needs six divisions plus a search over the even
// divides that tests one divide per cycle. req_chan.ready is low from an
// accepted request until the sequencer is idle again, which comes sooner
// when the target is below 1 kHz, as only the Hz to kHz division runs then.
// A finished response waits in an output register, so the next request
// is taken while the previous response is still unclaimed; only when that
// register is still full does the finished request wait longer.
module ssp_bit_clock_divider_search
   import sbcds_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   sbcds_req_if.sink             req_chan,
   sbcds_rsp_if.source           rsp_chan,
   input  wire                   psel,
   input  wire                   penable,
   input  wire                   pwrite,
   input  wire [CSR_ADDR_W-1:0]  paddr,
   input  wire [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // Sequencer states. Each DIV_* state runs one division on the shared unit.
   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_IDLE     = 4'd0;
   localparam logic [ST_W-1:0] ST_DIV_KHZ  = 4'd1;
   localparam logic [ST_W-1:0] ST_DIV_Q0   = 4'd2;
   localparam logic [ST_W-1:0] ST_SEARCH   = 4'd3;
   localparam logic [ST_W-1:0] ST_DIV_RATE = 4'd4;
   localparam logic [ST_W-1:0] ST_DIV_PER  = 4'd5;
   localparam logic [ST_W-1:0] ST_DIV_MIN  = 4'd6;
   localparam logic [ST_W-1:0] ST_DIV_ACH  = 4'd7;
   localparam logic [ST_W-1:0] ST_FINISH   = 4'd8;

   localparam int DW     = TARGET_W;          // divider operand width
   localparam int CNT_W  = $clog2(DW);
   localparam int KHZ_W  = 23;                // holds (2^32-1)/1000
   localparam int RATE_W = REF_W;             // holds ref/2 + 1
   localparam int PER_W  = REF_W - 1;         // holds ref/2
   localparam int LIM_W  = DIVIDE_W + 9;      // holds 257 * divide

   localparam logic [DIVIDE_W-1:0] DIV_FIRST_C = DIVIDE_W'(DIVIDE_FIRST);
   localparam logic [DIVIDE_W-1:0] DIV_STEP_C  = DIVIDE_W'(DIVIDE_STEP);
   localparam logic [DIVIDE_W-1:0] DIV_LAST_C  = DIVIDE_W'(DIVIDE_LAST);
   localparam logic [DIVIDE_W-1:0] DIV_FINAL_TRY_C = DIVIDE_W'(DIVIDE_LAST - DIVIDE_STEP);
   localparam logic [RATE_W-1:0]   RATE_MAX_C  = RATE_W'(RATE_MAX);

   // Sequencer state and configuration register.
   logic [ST_W-1:0]   state_ff, state_in;
   ref_khz_type       ref_ff;

   // Shared restoring divider.
   logic [DW-1:0]     rem_ff, rem_in;
   logic [DW-1:0]     quo_ff, quo_in;
   logic [DW-1:0]     den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DW:0]       rem_shift;
   logic [DW:0]       rem_trial;
   logic [DW-1:0]     step_rem;
   logic [DW-1:0]     step_quo;
   logic              div_last;

   // Working values of the search.
   logic [KHZ_W-1:0]    khz_ff, khz_in;
   ref_khz_type         q0_ff, q0_in;
   divide_type          divide_ff, divide_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic [PER_W-1:0]    per_ff, per_in;
   achieved_type        ach_ff, ach_in;
   logic                err_ff, err_in;
   logic [LIM_W-1:0]    limit;
   logic [RATE_W-1:0]   min_rate;
   logic [RATE_W-1:0]   rate_pick;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   divide_type          rsp_divide_ff, rsp_divide_in;
   rate_field_type      rsp_rate_ff, rsp_rate_in;
   achieved_type        rsp_ach_ff, rsp_ach_in;
   logic                rsp_err_ff, rsp_err_in;
   logic                rsp_free;

   logic                csr_write;

   // ------------------------------------------------------------------
   // Configuration port. Only the reference clock register exists, decoded on
   // paddr[2] alone; writes with paddr[2] set are dropped, reads there give zero.
   // ------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == CSR_IDX_REFERENCE);

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_IDX_REFERENCE) begin
         prdata = CSR_DATA_W'(ref_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= REF_W'(REF_RESET);
      end else if (csr_write) begin
         ref_ff <= pwdata[REF_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // One restoring division step: shift in the next dividend bit and
   // subtract the divisor when it fits.
   // ------------------------------------------------------------------
   assign rem_shift = {rem_ff, quo_ff[DW-1]};
   assign rem_trial = rem_shift - {1'b0, den_ff};
   assign div_last  = (cnt_ff == CNT_W'(DW - 1));

   always_comb begin
      if (rem_trial[DW]) begin
         step_rem = rem_shift[DW-1:0];
         step_quo = {quo_ff[DW-2:0], 1'b0};
      end else begin
         step_rem = rem_trial[DW-1:0];
         step_quo = {quo_ff[DW-2:0], 1'b1};
      end
   end

   // The search test: divide d qualifies when q0 / d <= 256, i.e. q0 < 257 * d.
   assign limit = {1'b0, divide_ff, 8'd0} + LIM_W'(divide_ff);

   assign min_rate  = step_quo[RATE_W-1:0] + RATE_W'(1);
   assign rate_pick = (rate_ff < min_rate) ? min_rate : rate_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready = (state_ff == ST_IDLE);

   // ------------------------------------------------------------------
   // Sequencer.
   // ------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      rem_in    = step_rem;
      quo_in    = step_quo;
      den_in    = den_ff;
      cnt_in    = cnt_ff + CNT_W'(1);
      khz_in    = khz_ff;
      q0_in     = q0_ff;
      divide_in = divide_ff;
      rate_in   = rate_ff;
      per_in    = per_ff;
      ach_in    = ach_ff;
      err_in    = err_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_divide_in = rsp_divide_ff;
      rsp_rate_in   = rsp_rate_ff;
      rsp_ach_in    = rsp_ach_ff;
      rsp_err_in    = rsp_err_ff;

      case (state_ff)
         ST_IDLE: begin
            rem_in = rem_ff;
            quo_in = quo_ff;
            cnt_in = cnt_ff;
            if (req_chan.valid) begin
               // Hz to kHz.
               rem_in   = '0;
               quo_in   = req_chan.target_hz;
               den_in   = DW'(HZ_PER_KHZ);
               cnt_in   = '0;
               err_in   = 1'b0;
               state_in = ST_DIV_KHZ;
            end
         end

         ST_DIV_KHZ: begin
            if (div_last) begin
               khz_in = step_quo[KHZ_W-1:0];
               if (step_quo == '0) begin
                  // Target below 1 kHz: report the fixed error answer.
                  err_in    = 1'b1;
                  divide_in = DIV_LAST_C;
                  rate_in   = RATE_MAX_C;
                  ach_in    = '0;
                  state_in  = ST_FINISH;
               end else begin
                  rem_in   = '0;
                  quo_in   = DW'(ref_ff);
                  den_in   = step_quo;
                  cnt_in   = '0;
                  state_in = ST_DIV_Q0;
               end
            end
         end

         ST_DIV_Q0: begin
            if (div_last) begin
               q0_in     = step_quo[REF_W-1:0];
               divide_in = DIV_FIRST_C;
               state_in  = ST_SEARCH;
            end
         end

         ST_SEARCH: begin
            rem_in = '0;
            quo_in = DW'(q0_ff);
            den_in = DW'(divide_ff);
            cnt_in = '0;
            if (q0_ff < REF_W'(limit)) begin
               state_in = ST_DIV_RATE;
            end else if (divide_ff == DIV_FINAL_TRY_C) begin
               // No divide fits: keep the quotient of the last one tried.
               divide_in = DIV_LAST_C;
               state_in  = ST_DIV_RATE;
            end else begin
               divide_in = divide_ff + DIV_STEP_C;
            end
         end

         ST_DIV_RATE: begin
            if (div_last) begin
               // A zero starting rate counts as one.
               rate_in  = (step_quo == '0) ? RATE_W'(1) : step_quo[RATE_W-1:0];
               rem_in   = '0;
               quo_in   = DW'(ref_ff);
               den_in   = DW'(divide_ff);
               cnt_in   = '0;
               state_in = ST_DIV_PER;
            end
         end

         ST_DIV_PER: begin
            if (div_last) begin
               per_in   = step_quo[PER_W-1:0];
               rem_in   = '0;
               quo_in   = step_quo;
               den_in   = DW'(khz_ff) + DW'(1);
               cnt_in   = '0;
               state_in = ST_DIV_MIN;
            end
         end

         ST_DIV_MIN: begin
            if (div_last) begin
               // Raise rate to the least keeping (ref / divide) / rate <= khz.
               rate_in  = rate_pick;
               rem_in   = '0;
               quo_in   = DW'(per_ff);
               den_in   = DW'(rate_pick);
               cnt_in   = '0;
               state_in = ST_DIV_ACH;
            end
         end

         ST_DIV_ACH: begin
            if (div_last) begin
               ach_in   = step_quo[ACHIEVED_W-1:0];
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            rem_in = rem_ff;
            quo_in = quo_ff;
            cnt_in = cnt_ff;
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_divide_in = divide_ff;
               rsp_rate_in   = (rate_ff > RATE_MAX_C) ? rate_field_type'(RATE_MAX - 1)
                                                       : RATE_FIELD_W'(rate_ff - RATE_W'(1));
               rsp_ach_in    = ach_ff;
               rsp_err_in    = err_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      den_ff        <= den_in;
      cnt_ff        <= cnt_in;
      khz_ff        <= khz_in;
      q0_ff         <= q0_in;
      divide_ff     <= divide_in;
      rate_ff       <= rate_in;
      per_ff        <= per_in;
      ach_ff        <= ach_in;
      err_ff        <= err_in;
      rsp_divide_ff <= rsp_divide_in;
      rsp_rate_ff   <= rsp_rate_in;
      rsp_ach_ff    <= rsp_ach_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.stage_divide     = rsp_divide_ff;
   assign rsp_chan.clock_rate_field = rsp_rate_ff;
   assign rsp_chan.achieved_khz     = rsp_ach_ff;
   assign rsp_chan.target_error     = rsp_err_ff;

endmodule

`default_nettype wire
